[design/axis_angle_view_rotation_top_assert.svh]
// assertion macros for the view rotation block
`ifndef AXIS_ANGLE_VIEW_ROTATION_TOP_ASSERT_SVH
`define AXIS_ANGLE_VIEW_ROTATION_TOP_ASSERT_SVH

// condition holds at every clock edge outside reset
`define AAVR_ASSERT(label, cond, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define AAVR_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[design/aavr_pkg.sv]
package aavr_pkg;
	localparam int CoordWidth = 32;
	localparam int AngleWidth = 16;
	localparam int AxisWidth  = 16;
	localparam int CordicSteps = 16;
	localparam int Depth = CordicSteps + 7;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;

	function automatic logic signed [33:0] atan_turn(input int i);
		logic signed [33:0] t;
		begin
			case (i)
				0: t = 34'sd536870912;
				1: t = 34'sd316933406;
				2: t = 34'sd167458907;
				3: t = 34'sd85004756;
				4: t = 34'sd42667331;
				5: t = 34'sd21354465;
				6: t = 34'sd10679838;
				7: t = 34'sd5340245;
				8: t = 34'sd2670163;
				9: t = 34'sd1335087;
				10: t = 34'sd667544;
				11: t = 34'sd333772;
				12: t = 34'sd166886;
				13: t = 34'sd83443;
				14: t = 34'sd41722;
				default: t = 34'sd20861;
			endcase
			return t;
		end
	endfunction

	// round a q.42 matrix element to q2.14 and clamp
	function automatic logic signed [15:0] round_q42(input logic signed [47:0] e);
		logic signed [47:0] r;
		begin
			r = (e + 48'sd134217728) >>> 28;
			if (r > 48'sd32767) return 16'sh7fff;
			else if (r < -48'sd32768) return 16'sh8000;
			else return r[15:0];
		end
	endfunction
endpackage

[design/axis_angle_view_rotation_top.sv]
// Axis-angle view rotation: each word carries an eye position, a look-at target, a unit axis
// (q1.14) and an angle (fraction of pi); the block returns eye + R*(target - eye), saturated,
// with R the Rodrigues matrix built from a 16-step cordic cosine and sine. The pipeline takes
// one word per cycle while the output is not stalled; its registers are the input register,
// one per cordic step, then matrix terms, full matrix elements, matrix rounding, products,
// sums and the final saturating add. A stall on the master side freezes the whole pipeline,
// so s_axis_tready follows m_axis_tready whenever the output holds a word.
// s_axis_tdata (from lsb): angle, axis_x, axis_y, axis_z, eye_x, eye_y, eye_z,
// target_x, target_y, target_z. m_axis_tdata (from lsb): new_target_x/y/z.
module axis_angle_view_rotation_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [255:0] s_axis_tdata, // angle, axis_x..z, eye_x..z, target_x..z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [95:0]  m_axis_tdata  // new_target_x, new_target_y, new_target_z
);
	localparam int N = aavr_pkg::CordicSteps;
	localparam int D = aavr_pkg::Depth;

	// stage enable: the whole pipe moves unless the output word is held
	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	logic [D-1:0] vld_q;

	// cordic stages, plus geometry carried alongside
	logic signed [33:0] cx_s [N+1];
	logic signed [33:0] cy_s [N+1];
	logic signed [33:0] cz_s [N+1];
	logic               flip_s [N+1];
	logic signed [15:0] ax_s [N+1][3];
	logic signed [32:0] v_s [N+1][3];
	logic signed [31:0] eye_s [N+6][3];

	// input unpack and phase fold
	logic [31:0] ph;
	logic        fl;
	logic [31:0] phf;
	always_comb begin
		ph = {s_axis_tdata[15:0], 16'd0};
		fl = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
		phf = fl ? ph + 32'h8000_0000 : ph;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[D-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s[0] <= aavr_pkg::CordicGain;
			cy_s[0] <= '0;
			cz_s[0] <= {{2{phf[31]}}, phf};
			flip_s[0] <= fl;
			for (int k = 0; k < 3; k++) begin
				ax_s[0][k] <= s_axis_tdata[16+16*k +: 16];
				eye_s[0][k] <= s_axis_tdata[64+32*k +: 32];
				v_s[0][k] <= {s_axis_tdata[160+32*k+31], s_axis_tdata[160+32*k +: 32]}
					- {s_axis_tdata[64+32*k+31], s_axis_tdata[64+32*k +: 32]};
			end
			for (int i = 0; i < N; i++) begin
				if (!cz_s[i][33]) begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - aavr_pkg::atan_turn(i);
				end else begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + aavr_pkg::atan_turn(i);
				end
				flip_s[i+1] <= flip_s[i];
				ax_s[i+1] <= ax_s[i];
				v_s[i+1] <= v_s[i];
			end
			for (int i = 0; i < N + 5; i++) eye_s[i+1] <= eye_s[i];
		end
	end

	// cos, sin in q2.14 after rounding
	logic signed [33:0] xf, yf, xr, yr;
	logic signed [17:0] c_w, s_w, k_w;
	always_comb begin
		xf = flip_s[N] ? -cx_s[N] : cx_s[N];
		yf = flip_s[N] ? -cy_s[N] : cy_s[N];
		xr = (xf + 34'sd32768) >>> 16;
		yr = (yf + 34'sd32768) >>> 16;
		c_w = xr[17:0];
		s_w = yr[17:0];
		k_w = 18'sd16384 - c_w;
	end

	// matrix stage a: k*a, s*a, c
	logic signed [33:0] ka_s1 [3];
	logic signed [33:0] sa_s1 [3];
	logic signed [17:0] c_s1;
	logic signed [15:0] ax_s1 [3];
	logic signed [32:0] v_s1 [3];
	// stage b: full q.42 elements
	logic signed [47:0] e_s2 [3][3];
	logic signed [32:0] v_s2 [3];
	// stage c: rounded elements
	logic signed [15:0] m_s3 [3][3];
	logic signed [32:0] v_s3 [3];
	// stage d: products
	logic signed [48:0] p_s4 [3][3];
	// stage e: sums
	logic signed [51:0] r_s5 [3];
	logic [95:0] out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1 <= c_w;
			for (int k = 0; k < 3; k++) begin
				ka_s1[k] <= 34'(k_w * ax_s[N][k]);
				sa_s1[k] <= 34'(s_w * ax_s[N][k]);
				ax_s1[k] <= ax_s[N][k];
				v_s1[k] <= v_s[N][k];
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (i == j)
						e_s2[i][j] <= 48'(ka_s1[i] * ax_s1[j]) + (48'(c_s1) <<< 28);
					else if ((i == 0 && j == 1) || (i == 1 && j == 2) || (i == 2 && j == 0))
						e_s2[i][j] <= 48'(ka_s1[i] * ax_s1[j]) - (48'(sa_s1[3-i-j]) <<< 14);
					else
						e_s2[i][j] <= 48'(ka_s1[i] * ax_s1[j]) + (48'(sa_s1[3-i-j]) <<< 14);
					m_s3[i][j] <= aavr_pkg::round_q42(e_s2[i][j]);
					p_s4[i][j] <= 49'(m_s3[i][j] * v_s3[j]);
				end
				v_s2[i] <= v_s1[i];
				v_s3[i] <= v_s2[i];
				r_s5[i] <= (52'(p_s4[i][0]) + 52'(p_s4[i][1]) + 52'(p_s4[i][2])
					+ 52'sd8192) >>> 14;
			end
			for (int i = 0; i < 3; i++) begin
				logic signed [52:0] n;
				n = 53'(eye_s[N+5][i]) + 53'(r_s5[i]);
				if (n > 53'sd2147483647) out_q[32*i +: 32] <= 32'h7fff_ffff;
				else if (n < -53'sd2147483648) out_q[32*i +: 32] <= 32'h8000_0000;
				else out_q[32*i +: 32] <= n[31:0];
			end
		end
	end

	assign m_axis_tvalid = vld_q[D-1];
	assign m_axis_tdata = out_q;

	`include "axis_angle_view_rotation_top_assert.svh"
	`AAVR_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed under stall")
	`AAVR_ASSERT_NEXT(a_stall_freeze, !adv, $stable(vld_q), "pipeline moved during stall")
	`AAVR_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready not tied to output state")
endmodule

[test/tb_axis_angle_view_rotation_top.sv]
`timescale 1ns / 100ps

module tb_axis_angle_view_rotation_top;
	typedef struct packed {
		logic signed [31:0] target_z, target_y, target_x;
		logic signed [31:0] eye_z, eye_y, eye_x;
		logic signed [15:0] axis_z, axis_y, axis_x;
		logic signed [15:0] angle;
	} view_word_t;

	typedef struct packed {
		logic signed [31:0] z, y, x;
	} target_word_t;

	// cordic arctangent table, turns scaled to 2^32
	localparam longint AtanStep [16] = '{536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861};
	localparam longint GainQ30 = 652032874;
	localparam int ItemCount = 600;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [255:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [95:0] m_axis_tdata;

	view_word_t pending_words[$];
	target_word_t expected_targets[$];
	int mismatches = 0;
	int checked = 0;
	bit stim_done = 0;
	int quiet_from, quiet_to;
	int cycle = 0;

	axis_angle_view_rotation_top uut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// floor division by 2^n on 64-bit values
	function automatic longint floor_shift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clamp_element(longint e);
		longint r;
		r = floor_shift(e + (64'sd1 <<< 27), 28);
		if (r > 32767) return 32767;
		if (r < -32768) return -32768;
		return r;
	endfunction

	function automatic target_word_t rotate_view(view_word_t w);
		logic [31:0] phase;
		bit flip;
		longint x, y, z, dx, dy, c, s, k, e;
		longint ax[3], eye[3], v[3], m[3][3], acc, n;
		target_word_t res;
		phase = {w.angle, 16'h0};
		flip = phase[31:30] == 2'b01 || phase[31:30] == 2'b10;
		if (flip) phase = phase + 32'h80000000;
		z = longint'($signed(phase));
		x = GainQ30;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= AtanStep[i];
			end else begin
				x += dx; y -= dy; z += AtanStep[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = floor_shift(x + 32768, 16);
		s = floor_shift(y + 32768, 16);
		k = 16384 - c;
		ax = '{w.axis_x, w.axis_y, w.axis_z};
		eye = '{w.eye_x, w.eye_y, w.eye_z};
		v[0] = longint'(w.target_x) - eye[0];
		v[1] = longint'(w.target_y) - eye[1];
		v[2] = longint'(w.target_z) - eye[2];
		for (int i = 0; i < 3; i++)
			m[i][i] = clamp_element(c * (64'sd1 <<< 28) + k * ax[i] * ax[i]);
		m[0][1] = clamp_element(k * ax[0] * ax[1] - ax[2] * s * 16384);
		m[1][0] = clamp_element(k * ax[0] * ax[1] + ax[2] * s * 16384);
		m[0][2] = clamp_element(k * ax[0] * ax[2] + ax[1] * s * 16384);
		m[2][0] = clamp_element(k * ax[0] * ax[2] - ax[1] * s * 16384);
		m[1][2] = clamp_element(k * ax[1] * ax[2] - ax[0] * s * 16384);
		m[2][1] = clamp_element(k * ax[1] * ax[2] + ax[0] * s * 16384);
		for (int i = 0; i < 3; i++) begin
			// |m*v| < 2^48, three terms fit easily in 64 bits
			acc = 0;
			for (int j = 0; j < 3; j++) acc += m[i][j] * v[j];
			n = eye[i] + floor_shift(acc + 8192, 14);
			if (n > 64'sd2147483647) n = 64'sd2147483647;
			if (n < -64'sd2147483648) n = -64'sd2147483648;
			if (i == 0) res.x = n[31:0];
			else if (i == 1) res.y = n[31:0];
			else res.z = n[31:0];
		end
		return res;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 32'h3fffff)) - 32'sd2097152;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 7))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return $urandom; // out of range, not a pure rotation
			default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
		endcase
	endfunction

	task automatic add_word(logic signed [15:0] ang, logic signed [15:0] a0, a1, a2,
			logic signed [31:0] e0, e1, e2, t0, t1, t2);
		view_word_t w;
		w = '{target_z: t2, target_y: t1, target_x: t0, eye_z: e2, eye_y: e1, eye_x: e0,
			axis_z: a2, axis_y: a1, axis_x: a0, angle: ang};
		pending_words.push_back(w);
	endtask

	// stimulus: directed corners then random words
	initial begin
		quiet_from = $urandom_range(150, 300);
		quiet_to = quiet_from + 200;
		add_word(0, 16384, 0, 0, 0, 0, 0, 65536, 0, 0);
		add_word(16'sh4000, 0, 0, 16384, 0, 0, 0, 65536, 0, 0);
		add_word(16'sh8000, 0, 16384, 0, 0, 0, 0, 65536, 131072, 0);    // angle of -pi
		add_word(16'sh7fff, 0, 16384, 0, 0, 0, 0, 65536, 0, 65536);
		add_word(16'shc000, 16384, 0, 0, 100, 200, 300, 400, 500, 600);
		add_word(16'sh2000, 16384, 16384, 16384, 0, 0, 0, 65536, 65536, 0);
		add_word(16'sh2000, -16384, -16384, -16384, 0, 0, 0, 65536, 0, 65536);
		add_word(16'sh4000, 0, 0, 16384, 32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0);
		add_word(16'sh4000, 0, 0, 16384, 32'sh80000000, 32'sh80000000, 0,
			32'sh7fffffff, 32'sh7fffffff, 0);
		add_word(16'sh8000, 16384, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		add_word(16'sh0001, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff);
		add_word(16'sh6000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000);
		add_word(16'shffff, 0, 0, 0, -5, -5, -5, 5, 5, 5);
		add_word(16'sha000, 11585, 11585, 0, 32'h00010000, 32'hffff0000, 0,
			32'h00030000, 32'h00020000, 32'hfffe0000);
		for (int i = 0; i < ItemCount; i++)
			add_word($urandom, rand_axis(), rand_axis(), rand_axis(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
	end

	// driver: keeps a word on the slave side, idles now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
		end else begin
			cycle <= cycle + 1;
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_words.size() > 0 &&
						((cycle > quiet_from && cycle < quiet_to) || $urandom_range(0, 99) >= 6)) begin
					expected_targets.push_back(rotate_view(pending_words[0]));
					s_axis_tdata <= pending_words.pop_front();
					s_axis_tvalid <= 1;
				end else begin
					s_axis_tvalid <= 0;
					if (pending_words.size() == 0) stim_done <= 1;
				end
			end
			m_axis_tready <= (cycle > quiet_from && cycle < quiet_to) || $urandom_range(0, 99) >= 6;
		end
	end

	// monitor: compares each result word with the oldest prediction
	always @(posedge clk) begin
		target_word_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_targets.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
			end else begin
				want = expected_targets.pop_front();
				checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected x %0d y %0d z %0d, got x %0d y %0d z %0d",
							want.x, want.y, want.z, got.x, got.y, got.z);
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		wait (stim_done && expected_targets.size() == 0);
		repeat (60) @(posedge clk);
		$display("checked %0d rotated targets, directed corners plus random axes, angles", checked);
		if (mismatches == 0 && expected_targets.size() == 0)
			$display("tb_axis_angle_view_rotation_top OK");
		else
			$display("tb_axis_angle_view_rotation_top NOT OK");
		$finish;
	end

	initial begin
		#200000;
		$display("tb_axis_angle_view_rotation_top NOT OK");
		$finish;
	end
endmodule
